// File: rtl/simonenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simonenc_pkg
// Types and constants shared by the SIMON encrypt sequencer and datapath.
// ----------------------------------------------------------------------------
package simonenc_pkg;

  // Widths of the external fields
  localparam int FIELD_BITS = 32;
  localparam int KEY_REGS   = 4;
  localparam int CFG_IDX_BITS = 2;

  // Cipher constants
  localparam int ZLEN      = 62;
  localparam int KS_CONST  = 3;
  localparam int KS_ROT    = 3;
  localparam int F_ROT_A   = 1;
  localparam int F_ROT_B   = 8;
  localparam int F_ROT_C   = 2;
  localparam int Z_SEQS    = 5;

  // z sequences, element 0 at the MSB
  localparam logic [ZLEN-1:0] Z_SEQ [Z_SEQS] = '{
    62'b1111101000_1001010110_0001110011_0111110100_0100101011_0000111001_10,
    62'b1000111011_1110010011_0000101101_0100011101_1111001001_1000010110_10,
    62'b1010111101_1100000011_0100100110_0010100001_0001111110_0101101100_11,
    62'b1101101110_1011000110_0101111000_0001001000_1010011100_1101000011_11,
    62'b1101000111_1001101011_0110001000_0001011100_0011001010_0100111011_11
  };

  typedef logic [KEY_REGS-1:0][FIELD_BITS-1:0] key_regs_t;

  // Datapath requests decoded from the control word
  typedef struct packed {
    logic load;
    logic round;
    logic write;
  } cmd_t;

  // Datapath status fed back to the sequencer
  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/simon_block_encrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simon_block_encrypt_unit
// SIMON block encryption (SIMON64/128 by default), microcoded control.
// ----------------------------------------------------------------------------
// Usage:
//   Key words are written over the cfg channel (cfg_valid/cfg_ready, index,
//   data); index 0 is the most significant key word. cfg_ready is always high.
//   Write the key only while no block is in flight.
//   A plaintext request (plain_upper, plain_lower) is taken when in_valid is
//   high and in_stall is low. The ciphertext appears on cipher_upper and
//   cipher_lower with out_valid, and is taken when out_stall is low.
// Timing:
//   After a request is taken, the round loop runs ROUND_COUNT rounds (one
//   round and one key step per cycle on a single round unit), then the write
//   step writes the result register and raises out_valid. The write step
//   also accepts the next request, so back-to-back blocks overlap the
//   result write with the load of the next block.
// Reset and stalls:
//   rst clears the key registers to zero, the step counter and out_valid.
//   While the receiver stalls a finished result, the next block still runs;
//   it waits at the write step until the result register frees.
// ----------------------------------------------------------------------------
module simon_block_encrypt_unit #(
  parameter int WORD_BITS      = 32,
  parameter int KEY_WORDS      = 4,
  parameter int ROUND_COUNT    = 44,
  parameter int SEQUENCE_INDEX = 3
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [simonenc_pkg::FIELD_BITS-1:0]     plain_upper,
  input  logic [simonenc_pkg::FIELD_BITS-1:0]     plain_lower,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [simonenc_pkg::FIELD_BITS-1:0]     cipher_upper,
  output logic [simonenc_pkg::FIELD_BITS-1:0]     cipher_lower,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [simonenc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [simonenc_pkg::FIELD_BITS-1:0]     cfg_data
);
  import simonenc_pkg::*;

  key_regs_t key_regs;
  cmd_t      cmd;
  status_t   status;
  logic      in_ready;

  // Key registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_regs[cfg_index] <= cfg_data;
    end
  end

  assign in_stall = ~in_ready;

  simonenc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  simonenc_datapath #(
    .WORD_BITS      (WORD_BITS),
    .KEY_WORDS      (KEY_WORDS),
    .ROUND_COUNT    (ROUND_COUNT),
    .SEQUENCE_INDEX (SEQUENCE_INDEX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key_regs     (key_regs),
    .plain_upper  (plain_upper),
    .plain_lower  (plain_lower),
    .out_stall    (out_stall),
    .status       (status),
    .out_valid    (out_valid),
    .cipher_upper (cipher_upper),
    .cipher_lower (cipher_lower)
  );

endmodule

// File: rtl/simonenc_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simonenc_sequencer
// Step counter and control store; decodes one control word per step.
// ----------------------------------------------------------------------------
module simonenc_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  simonenc_pkg::status_t status,
  output logic                  in_ready,
  output simonenc_pkg::cmd_t    cmd
);
  import simonenc_pkg::*;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_ROUND = 2'd1;
  localparam step_t STEP_WRITE = 2'd2;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_LAST,
    COND_OUT_FREE,
    COND_ALWAYS
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  round_en;
    logic  out_write;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // Control store: idle/accept, round loop, result write (also accepts)
  function automatic ctl_word_t ctl_rom(input step_t s);
    ctl_word_t w;
    unique case (s)
      STEP_IDLE:  w = '{1'b1, 1'b0, 1'b0, COND_NONE,     STEP_IDLE};
      STEP_ROUND: w = '{1'b0, 1'b1, 1'b0, COND_LAST,     STEP_WRITE};
      STEP_WRITE: w = '{1'b1, 1'b0, 1'b1, COND_OUT_FREE, STEP_IDLE};
      default:    w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

  step_t     step;
  step_t     step_next;
  ctl_word_t ctl;
  logic      cond_hit;
  logic      accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Decode, handshake and next step
  always_comb begin
    ctl = ctl_rom(step);
    unique case (ctl.cond)
      COND_NONE:     cond_hit = 1'b0;
      COND_LAST:     cond_hit = status.last;
      COND_OUT_FREE: cond_hit = status.out_free;
      COND_ALWAYS:   cond_hit = 1'b1;
      default:       cond_hit = 1'b1;
    endcase

    // a write step may only take a request once the result slot frees
    in_ready  = ctl.in_ready & (~ctl.out_write | status.out_free);
    accept    = in_ready & in_valid;
    cmd.load  = accept;
    cmd.round = ctl.round_en;
    cmd.write = ctl.out_write & status.out_free;

    priority if (accept) begin
      step_next = STEP_ROUND;
    end else if (cond_hit) begin
      step_next = ctl.target;
    end else begin
      step_next = step;
    end
  end

endmodule

// File: rtl/simonenc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simonenc_datapath
// Round function, on-the-fly key schedule, round counter and result register.
// ----------------------------------------------------------------------------
module simonenc_datapath #(
  parameter int WORD_BITS      = 32,
  parameter int KEY_WORDS      = 4,
  parameter int ROUND_COUNT    = 44,
  parameter int SEQUENCE_INDEX = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  simonenc_pkg::cmd_t            cmd,
  input  simonenc_pkg::key_regs_t       key_regs,
  input  logic [simonenc_pkg::FIELD_BITS-1:0] plain_upper,
  input  logic [simonenc_pkg::FIELD_BITS-1:0] plain_lower,
  input  logic                          out_stall,
  output simonenc_pkg::status_t         status,
  output logic                          out_valid,
  output logic [simonenc_pkg::FIELD_BITS-1:0] cipher_upper,
  output logic [simonenc_pkg::FIELD_BITS-1:0] cipher_lower
);
  import simonenc_pkg::*;

  localparam int KW  = (KEY_WORDS < 2) ? 2 : ((KEY_WORDS > 4) ? 4 : KEY_WORDS);
  localparam int RW  = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int ZW  = $clog2(ZLEN);
  localparam int SEQ_SEL = SEQUENCE_INDEX % Z_SEQS;
  localparam logic [ZLEN-1:0] ZROW = Z_SEQ[SEQ_SEL];

  function automatic logic [WORD_BITS-1:0] rotl(input logic [WORD_BITS-1:0] v,
                                                 input int n);
    return (v << n) | (v >> (WORD_BITS - n));
  endfunction

  function automatic logic [WORD_BITS-1:0] rotr(input logic [WORD_BITS-1:0] v,
                                                 input int n);
    return (v >> n) | (v << (WORD_BITS - n));
  endfunction

  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] y;
  logic [WORD_BITS-1:0] ks [KW];
  logic [WORD_BITS-1:0] x_next;
  logic [WORD_BITS-1:0] key_next;
  logic [RW-1:0]        rnd;
  logic [ZW-1:0]        zi;
  logic                 z_bit;

  // One round and one key schedule step
  always_comb begin
    logic [WORD_BITS-1:0] t;
    x_next = y ^ (rotl(x, F_ROT_A) & rotl(x, F_ROT_B)) ^ rotl(x, F_ROT_C) ^ ks[0];
    t = rotr(ks[KW-1], KS_ROT);
    if (KW == 4) begin
      t = t ^ ks[1];
    end
    t = t ^ rotr(t, 1);
    z_bit = ZROW[ZW'(ZLEN - 1) - zi];
    key_next = ~ks[0] ^ t ^ WORD_BITS'(z_bit) ^ WORD_BITS'(KS_CONST);
  end

  // Block and key registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= WORD_BITS'(plain_upper);
      y <= WORD_BITS'(plain_lower);
      for (int w = 0; w < KW; w++) begin
        ks[KW-1-w] <= WORD_BITS'(key_regs[w]);
      end
    end else if (cmd.round) begin
      x <= x_next;
      y <= x;
      for (int w = 0; w < KW - 1; w++) begin
        ks[w] <= ks[w+1];
      end
      ks[KW-1] <= key_next;
    end
  end

  // Round counter and z position
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
      zi  <= '0;
    end else if (cmd.load) begin
      rnd <= '0;
      zi  <= '0;
    end else if (cmd.round) begin
      rnd <= rnd + 1'b1;
      zi  <= (zi == ZW'(ZLEN - 1)) ? '0 : zi + 1'b1;
    end
  end

  assign status.last     = (rnd == RW'(ROUND_COUNT - 1));
  assign status.out_free = ~out_valid | ~out_stall;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      cipher_upper <= FIELD_BITS'(x);
      cipher_lower <= FIELD_BITS'(y);
    end
  end

endmodule

// File: tb/sv/simon_block_encrypt_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simon_block_encrypt_unit_tb
// Self-checking bench for the SIMON64/128 block encryption unit. Each plaintext
// request is encrypted by a bit-exact predictor that uses a mirror of the key
// registers. The expected ciphertext is queued, and each result taken from the
// block is checked against it, field by field. The run covers the reset key,
// a published known-answer block, extreme and random keys, a long receiver
// hold-off that backs the block up, and random traffic under three idle mixes.
// ----------------------------------------------------------------------------
module simon_block_encrypt_unit_tb;
  import simonenc_pkg::*;

  localparam int WORD_BITS      = 32;
  localparam int KEY_WORDS      = 4;
  localparam int ROUND_COUNT    = 44;
  localparam int SEQUENCE_INDEX = 3;

  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = ROUND_COUNT + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef logic [FIELD_BITS-1:0] word_t;

  // Key register indexes on the cfg channel
  typedef enum logic [CFG_IDX_BITS-1:0] {
    KEY_WORD_0 = 2'd0,
    KEY_WORD_1 = 2'd1,
    KEY_WORD_2 = 2'd2,
    KEY_WORD_3 = 2'd3
  } key_reg_t;

  typedef struct {
    word_t upper;
    word_t lower;
  } cipher_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  word_t       plain_upper;
  word_t       plain_lower;
  logic        out_valid;
  logic        out_stall;
  word_t       cipher_upper;
  word_t       cipher_lower;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  word_t       cfg_data;

  word_t   key_mirror [KEY_REGS];
  cipher_t cipher_expected_q [$];
  int      mismatch_count;
  int      sender_idle_pct;
  int      receiver_stall_pct;
  int      stall_hold_cycles;
  int      quiet_cycles;

  simon_block_encrypt_unit #(
    .WORD_BITS      (WORD_BITS),
    .KEY_WORDS      (KEY_WORDS),
    .ROUND_COUNT    (ROUND_COUNT),
    .SEQUENCE_INDEX (SEQUENCE_INDEX)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .plain_upper  (plain_upper),
    .plain_lower  (plain_lower),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_upper (cipher_upper),
    .cipher_lower (cipher_lower),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------------------

  // n in 1..FIELD_BITS-1
  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (FIELD_BITS - n));
  endfunction

  function automatic word_t rotr(input word_t v, input int n);
    return rotl(v, FIELD_BITS - n);
  endfunction

  function automatic word_t round_mix(input word_t v);
    return (rotl(v, F_ROT_A) & rotl(v, F_ROT_B)) ^ rotl(v, F_ROT_C);
  endfunction

  // Full encryption with on-the-fly key schedule from the key mirror
  function automatic cipher_t simon_encrypt(input word_t upper, input word_t lower);
    word_t   ks [KEY_REGS];
    word_t   x;
    word_t   y;
    word_t   t;
    word_t   nk;
    cipher_t c;
    for (int w = 0; w < KEY_WORDS; w++) ks[KEY_WORDS-1-w] = key_mirror[w];
    x = upper;
    y = lower;
    for (int r = 0; r < ROUND_COUNT; r++) begin
      t = x;
      x = y ^ round_mix(x) ^ ks[0];
      y = t;
      // next round key
      nk = rotr(ks[KEY_WORDS-1], KS_ROT);
      if (KEY_WORDS == 4) nk = nk ^ ks[1];
      nk = nk ^ rotr(nk, 1);
      nk = ~ks[0] ^ nk ^ word_t'(Z_SEQ[SEQUENCE_INDEX % Z_SEQS][ZLEN-1-(r % ZLEN)])
           ^ word_t'(KS_CONST);
      for (int w = 0; w < KEY_WORDS - 1; w++) ks[w] = ks[w+1];
      ks[KEY_WORDS-1] = nk;
    end
    c.upper = x;
    c.lower = y;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input word_t exp_w, input word_t act_w);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %08h, got %08h", field, exp_w, act_w);
  endtask

  always @(posedge clk) begin : check_results
    cipher_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      if (cipher_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: %08h %08h", cipher_upper, cipher_lower);
      end else begin
        exp_c = cipher_expected_q.pop_front();
        if (cipher_upper !== exp_c.upper)
          report_mismatch("cipher_upper", exp_c.upper, cipher_upper);
        if (cipher_lower !== exp_c.lower)
          report_mismatch("cipher_lower", exp_c.lower, cipher_lower);
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_hold_cycles > 0) begin
      out_stall <= 1'b1;
      stall_hold_cycles <= stall_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly uniform words, with zeros, ones and single-bit patterns mixed in
  function automatic word_t random_word();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      6: return '0;
      7: return '1;
      8: return word_t'(1) << $urandom_range(FIELD_BITS - 1);
      9: return ~(word_t'(1) << $urandom_range(FIELD_BITS - 1));
      default: return $urandom;
    endcase
  endfunction

  // Send one plaintext request; valid stays high into the next call
  task automatic send_block(input word_t upper, input word_t lower);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    plain_upper <= upper;
    plain_lower <= lower;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_expected_q.push_back(simon_encrypt(upper, lower));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_key_reg(input key_reg_t idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_mirror[idx] = data;
  endtask

  // Load all four key words while the block is idle
  task automatic load_key(input word_t w0, input word_t w1, input word_t w2, input word_t w3);
    wait_idle();
    write_key_reg(KEY_WORD_0, w0);
    write_key_reg(KEY_WORD_1, w1);
    write_key_reg(KEY_WORD_2, w2);
    write_key_reg(KEY_WORD_3, w3);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Key left at its reset value of zero; plaintext extremes
  task automatic test_reset_key();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block(32'h8000_0000, 32'h0000_0001);
  endtask

  // Published SIMON64/128 vector plus neighbors
  task automatic test_known_answer();
    load_key(32'h1b1a_1918, 32'h1312_1110, 32'h0b0a_0908, 32'h0302_0100);
    send_block(32'h656b_696c, 32'h2064_6e75);
    send_block(32'h656b_696d, 32'h2064_6e75);
    send_block(32'h656b_696c, 32'hA064_6e75);
  endtask

  // Key extremes: all ones, then mixed zero, all-ones and single-bit words
  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(32'hAAAA_AAAA, 32'h5555_5555);
    send_block(32'h0000_0001, 32'h8000_0000);
    load_key(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    send_block('0, '0);
    send_block('1, '0);
    send_block(32'h0123_4567, 32'h89AB_CDEF);
    load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE);
    send_block('0, '1);
    send_block(32'hFFFF_0000, 32'h0000_FFFF);
  endtask

  // Receiver holds off while the sender keeps offering; then drain fully and send six more
  task automatic test_backpressure();
    load_key($urandom, $urandom, $urandom, $urandom);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    stall_hold_cycles  = HOLD_CYCLES;
    repeat (12) send_block($urandom, $urandom);
    wait_idle();
    repeat (6) send_block(random_word(), random_word());
  endtask

  // Random blocks in key epochs under a given idle mix
  task automatic test_random_traffic(input int items, input int in_pct, input int out_pct);
    int sent;
    sent = 0;
    sender_idle_pct    = in_pct;
    receiver_stall_pct = out_pct;
    while (sent < items) begin
      load_key(random_word(), random_word(), random_word(), random_word());
      repeat ($urandom_range(80, 20)) begin
        send_block(random_word(), random_word());
        sent++;
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    plain_upper <= '0;
    plain_lower <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= KEY_WORD_0;
    cfg_data    <= '0;
    for (int w = 0; w < KEY_REGS; w++) key_mirror[w] = '0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    stall_hold_cycles  = 0;
    quiet_cycles       = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_known_answer();
    test_key_extremes();
    test_backpressure();
    test_random_traffic(266, 35, 59);
    test_random_traffic(266, 59, 35);
    test_random_traffic(266, 0, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cipher_expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
